// ===== rtl/tt_pkg.sv =====
// Package for the tempo tick generator: widths, reset defaults, request and
// register codes, and the structs passed between the rate and core blocks.
// No dependencies.
package tt_pkg;

	// Datapath widths.
	localparam int ACC_W  = 42;
	localparam int CNT_W  = 32;
	localparam int SR_W   = 20;
	localparam int TB_W   = 16;
	localparam int PER_W  = 16;
	localparam int DIV_W  = 8;
	localparam int DX_W   = SR_W + PER_W;
	localparam int CIDX_W = 3;

	// Register defaults after reset.
	localparam logic [SR_W-1:0]  DEF_SAMPLE_RATE = SR_W'(44100);
	localparam logic [TB_W-1:0]  DEF_TEMPO_BEATS = TB_W'(140);
	localparam logic [PER_W-1:0] DEF_PERIOD_SEC  = PER_W'(60);
	localparam logic [DIV_W-1:0] DEF_TICKS_BEAT  = DIV_W'(24);
	localparam logic [DIV_W-1:0] DEF_BEATS_BAR   = DIV_W'(4);
	localparam int DEF_TICKS_PER_TEMPO_BEAT = 24;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_ADVANCE = 3'd0,
		REQ_RESET   = 3'd1,
		REQ_ARM     = 3'd2,
		REQ_START   = 3'd3,
		REQ_STOP    = 3'd4
	} req_t;

	// Wait kinds, also the pending wait state.
	typedef enum logic [2:0] {
		WK_NONE  = 3'd0,
		WK_TICKS = 3'd1,
		WK_BEATS = 3'd2,
		WK_BARS  = 3'd3,
		WK_NEXT  = 3'd4
	} wait_kind_t;

	// Fired event codes.
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_TICK = 2'd1,
		EV_BEAT = 2'd2,
		EV_BAR  = 2'd3
	} event_t;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_SAMPLE_RATE = 3'd0,
		CFG_TEMPO_BEATS = 3'd1,
		CFG_PERIOD_SEC  = 3'd2,
		CFG_TICKS_BEAT  = 3'd3,
		CFG_BEATS_BAR   = 3'd4
	} cfg_idx_t;

	// Accumulator steps and countdown reloads handed to the core.
	typedef struct packed {
		logic             busy;
		logic [ACC_W-1:0] step_tick;
		logic [ACC_W-1:0] step_idle;
		logic [ACC_W-1:0] load;
		logic [DIV_W-1:0] tick_reload;
		logic [DIV_W-1:0] beat_reload;
	} rate_cfg_t;

	// One result item.
	typedef struct packed {
		logic             ticked;
		event_t           ev;
		logic [CNT_W-1:0] ticks;
		logic [CNT_W-1:0] beats;
		logic [CNT_W-1:0] bars;
	} result_t;

	// Accumulator start value 2*dy - dx, wrapped to the accumulator width.
	function automatic logic [ACC_W-1:0] load_value(input logic [ACC_W-1:0] dx,
			input logic [ACC_W-1:0] dy);
		return (dy << 1) - dx;
	endfunction

endpackage

// ===== rtl/tt_rate.sv =====
// Configuration registers and the two-stage computation of the Bresenham
// step values (product stage, then step stage). Depends on tt_pkg.
module tt_rate #(
	parameter int TICKS_PER_TEMPO_BEAT = tt_pkg::DEF_TICKS_PER_TEMPO_BEAT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tt_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [tt_pkg::SR_W-1:0]    cfg_data,
	output tt_pkg::rate_cfg_t          rate_cfg
);

	localparam int TPB_W = $clog2(TICKS_PER_TEMPO_BEAT + 1);
	localparam int DY_W  = tt_pkg::TB_W + TPB_W;
	localparam logic [DY_W-1:0] TPB_C = DY_W'(TICKS_PER_TEMPO_BEAT);
	localparam logic [tt_pkg::DX_W-1:0] DX_RST =
		tt_pkg::DX_W'(tt_pkg::DEF_SAMPLE_RATE) * tt_pkg::DX_W'(tt_pkg::DEF_PERIOD_SEC);
	localparam logic [DY_W-1:0] DY_RST = DY_W'(tt_pkg::DEF_TEMPO_BEATS) * TPB_C;
	localparam logic [tt_pkg::ACC_W-1:0] DX42_RST = tt_pkg::ACC_W'(DX_RST);
	localparam logic [tt_pkg::ACC_W-1:0] DY42_RST = tt_pkg::ACC_W'(DY_RST);

	logic [tt_pkg::SR_W-1:0]  sample_rate_q;
	logic [tt_pkg::TB_W-1:0]  tempo_beats_q;
	logic [tt_pkg::PER_W-1:0] period_q;
	logic [tt_pkg::DIV_W-1:0] tick_reload_q;
	logic [tt_pkg::DIV_W-1:0] beat_reload_q;
	logic [1:0]               settle_q;
	logic [tt_pkg::DX_W-1:0]  dx_s1;
	logic [DY_W-1:0]          dy_s1;
	logic [tt_pkg::ACC_W-1:0] step_tick_s2;
	logic [tt_pkg::ACC_W-1:0] step_idle_s2;
	logic [tt_pkg::ACC_W-1:0] load_s2;
	logic [tt_pkg::ACC_W-1:0] dx42;
	logic [tt_pkg::ACC_W-1:0] dy42;
	logic                     cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Register writes; the settle shift marks the steps as stale while the product and step stages recompute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= tt_pkg::DEF_SAMPLE_RATE;
			tempo_beats_q <= tt_pkg::DEF_TEMPO_BEATS;
			period_q      <= tt_pkg::DEF_PERIOD_SEC;
			tick_reload_q <= tt_pkg::DEF_TICKS_BEAT;
			beat_reload_q <= tt_pkg::DEF_BEATS_BAR;
			settle_q      <= 2'b00;
		end else begin
			settle_q <= cfg_wr ? 2'b11 : {1'b0, settle_q[1]};
			if (cfg_wr) begin
				unique case (tt_pkg::cfg_idx_t'(cfg_index))
					tt_pkg::CFG_SAMPLE_RATE: sample_rate_q <= cfg_data;
					tt_pkg::CFG_TEMPO_BEATS: tempo_beats_q <= cfg_data[tt_pkg::TB_W-1:0];
					tt_pkg::CFG_PERIOD_SEC:  period_q      <= cfg_data[tt_pkg::PER_W-1:0];
					tt_pkg::CFG_TICKS_BEAT:  tick_reload_q <= cfg_data[tt_pkg::DIV_W-1:0];
					tt_pkg::CFG_BEATS_BAR:   beat_reload_q <= cfg_data[tt_pkg::DIV_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Product stage: dx = sample rate times period, dy = tempo beats times ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_s1 <= DX_RST;
			dy_s1 <= DY_RST;
		end else begin
			dx_s1 <= tt_pkg::DX_W'(sample_rate_q) * tt_pkg::DX_W'(period_q);
			dy_s1 <= DY_W'(tempo_beats_q) * TPB_C;
		end
	end

	assign dx42 = tt_pkg::ACC_W'(dx_s1);
	assign dy42 = tt_pkg::ACC_W'(dy_s1);

	// Step stage: the two accumulator increments and the start value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_tick_s2 <= (DY42_RST << 1) - (DX42_RST << 1);
			step_idle_s2 <= DY42_RST << 1;
			load_s2      <= tt_pkg::load_value(DX42_RST, DY42_RST);
		end else begin
			step_tick_s2 <= (dy42 << 1) - (dx42 << 1);
			step_idle_s2 <= dy42 << 1;
			load_s2      <= tt_pkg::load_value(dx42, dy42);
		end
	end

	assign rate_cfg.busy        = |settle_q;
	assign rate_cfg.step_tick   = step_tick_s2;
	assign rate_cfg.step_idle   = step_idle_s2;
	assign rate_cfg.load        = load_s2;
	assign rate_cfg.tick_reload = tick_reload_q;
	assign rate_cfg.beat_reload = beat_reload_q;

endmodule

// ===== rtl/tt_core.sv =====
// Transport state: Bresenham accumulator, tick/beat/bar counters, countdowns
// and the armed wait. Computes one request's result. Depends on tt_pkg.
module tt_core #(
	parameter int TICKS_PER_TEMPO_BEAT = tt_pkg::DEF_TICKS_PER_TEMPO_BEAT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [2:0]                 req_type,
	input  logic [2:0]                 wait_kind,
	input  logic [15:0]                wait_count,
	input  tt_pkg::rate_cfg_t          rate_cfg,
	output tt_pkg::result_t            res
);

	localparam logic [tt_pkg::ACC_W-1:0] DX_RST = tt_pkg::ACC_W'(
		tt_pkg::DX_W'(tt_pkg::DEF_SAMPLE_RATE) * tt_pkg::DX_W'(tt_pkg::DEF_PERIOD_SEC));
	localparam logic [tt_pkg::ACC_W-1:0] DY_RST = tt_pkg::ACC_W'(
		tt_pkg::ACC_W'(tt_pkg::DEF_TEMPO_BEATS) * tt_pkg::ACC_W'(TICKS_PER_TEMPO_BEAT));
	localparam logic [tt_pkg::ACC_W-1:0] ACC_RST = tt_pkg::load_value(DX_RST, DY_RST);

	logic [tt_pkg::ACC_W-1:0] acc_q,        acc_n;
	logic [tt_pkg::CNT_W-1:0] ticks_q,      ticks_n;
	logic [tt_pkg::CNT_W-1:0] beats_q,      beats_n;
	logic [tt_pkg::CNT_W-1:0] bars_q,       bars_n;
	logic [tt_pkg::DIV_W-1:0] ticks_left_q, ticks_left_n;
	logic [tt_pkg::DIV_W-1:0] beats_left_q, beats_left_n;
	tt_pkg::wait_kind_t       pending_q,    pending_n;
	logic [tt_pkg::CNT_W-1:0] target_q,     target_n;
	logic                     stopped_q,    stopped_n;
	logic                     ticked;
	tt_pkg::event_t           ev;

	// True once the count has reached the target, robust across wrap.
	function automatic logic reached(input logic [tt_pkg::CNT_W-1:0] count,
			input logic [tt_pkg::CNT_W-1:0] target);
		logic [tt_pkg::CNT_W-1:0] diff;
		diff = count - target;
		return !diff[tt_pkg::CNT_W-1];
	endfunction

	// Next state and result for the request at the input.
	always_comb begin
		acc_n        = acc_q;
		ticks_n      = ticks_q;
		beats_n      = beats_q;
		bars_n       = bars_q;
		ticks_left_n = ticks_left_q;
		beats_left_n = beats_left_q;
		pending_n    = pending_q;
		target_n     = target_q;
		stopped_n    = stopped_q;
		ticked       = 1'b0;
		ev           = tt_pkg::EV_NONE;
		unique case (tt_pkg::req_t'(req_type))
			tt_pkg::REQ_ADVANCE: begin
				if (!acc_q[tt_pkg::ACC_W-1]) begin
					acc_n   = acc_q + rate_cfg.step_tick;
					ticked  = 1'b1;
					ticks_n = ticks_q + tt_pkg::CNT_W'(1);
					// Beat and bar countdowns.
					if (ticks_left_q <= tt_pkg::DIV_W'(1)) begin
						ticks_left_n = rate_cfg.tick_reload;
						beats_n      = beats_q + tt_pkg::CNT_W'(1);
						if (beats_left_q <= tt_pkg::DIV_W'(1)) begin
							beats_left_n = rate_cfg.beat_reload;
							bars_n       = bars_q + tt_pkg::CNT_W'(1);
						end else begin
							beats_left_n = beats_left_q - tt_pkg::DIV_W'(1);
						end
					end else begin
						ticks_left_n = ticks_left_q - tt_pkg::DIV_W'(1);
					end
					// Armed wait fires only while running.
					if (!stopped_q) begin
						case (pending_q)
							tt_pkg::WK_TICKS: begin
								if (reached(ticks_n, target_q)) begin
									pending_n = tt_pkg::WK_NONE;
									ev        = tt_pkg::EV_TICK;
								end
							end
							tt_pkg::WK_BEATS: begin
								if (reached(beats_n, target_q)) begin
									pending_n = tt_pkg::WK_NONE;
									ev        = tt_pkg::EV_BEAT;
								end
							end
							tt_pkg::WK_BARS: begin
								if (reached(bars_n, target_q)) begin
									pending_n = tt_pkg::WK_NONE;
									ev        = tt_pkg::EV_BAR;
								end
							end
							tt_pkg::WK_NEXT: begin
								pending_n = tt_pkg::WK_NONE;
								ev        = tt_pkg::EV_TICK;
							end
							default: ;
						endcase
					end
				end else begin
					acc_n = acc_q + rate_cfg.step_idle;
				end
			end
			tt_pkg::REQ_RESET: begin
				acc_n        = rate_cfg.load;
				ticks_n      = '0;
				beats_n      = '0;
				bars_n       = '0;
				ticks_left_n = '0;
				beats_left_n = '0;
				pending_n    = tt_pkg::WK_NONE;
				target_n     = '0;
			end
			tt_pkg::REQ_ARM: begin
				case (tt_pkg::wait_kind_t'(wait_kind))
					tt_pkg::WK_NONE: pending_n = tt_pkg::WK_NONE;
					tt_pkg::WK_TICKS: begin
						pending_n = tt_pkg::WK_TICKS;
						target_n  = ticks_q + tt_pkg::CNT_W'(wait_count);
					end
					tt_pkg::WK_BEATS: begin
						pending_n = tt_pkg::WK_BEATS;
						target_n  = beats_q + tt_pkg::CNT_W'(wait_count);
					end
					tt_pkg::WK_BARS: begin
						pending_n = tt_pkg::WK_BARS;
						target_n  = bars_q + tt_pkg::CNT_W'(wait_count);
					end
					tt_pkg::WK_NEXT: pending_n = tt_pkg::WK_NEXT;
					default: ;
				endcase
			end
			tt_pkg::REQ_START: stopped_n = 1'b0;
			tt_pkg::REQ_STOP: begin
				stopped_n = 1'b1;
				pending_n = tt_pkg::WK_NONE;
			end
			default: ;
		endcase
	end

	// State registers, updated on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= ACC_RST;
			ticks_q      <= '0;
			beats_q      <= '0;
			bars_q       <= '0;
			ticks_left_q <= '0;
			beats_left_q <= '0;
			pending_q    <= tt_pkg::WK_NONE;
			target_q     <= '0;
			stopped_q    <= 1'b1;
		end else if (accept) begin
			acc_q        <= acc_n;
			ticks_q      <= ticks_n;
			beats_q      <= beats_n;
			bars_q       <= bars_n;
			ticks_left_q <= ticks_left_n;
			beats_left_q <= beats_left_n;
			pending_q    <= pending_n;
			target_q     <= target_n;
			stopped_q    <= stopped_n;
		end
	end

	assign res.ticked = ticked;
	assign res.ev     = ev;
	assign res.ticks  = ticks_n;
	assign res.beats  = beats_n;
	assign res.bars   = bars_n;

	// A fired event needs a tick while running.
	a_event_needs_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ev != tt_pkg::EV_NONE) |-> (ticked && !stopped_q))
		else $error("wait event without a running tick");

	// A stop request leaves no wait pending.
	a_stop_clears_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == tt_pkg::REQ_STOP) |=> (pending_q == tt_pkg::WK_NONE && stopped_q))
		else $error("stop did not clear the pending wait");

	// A reset request zeroes all counts.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == tt_pkg::REQ_RESET) |=>
		(ticks_q == '0 && beats_q == '0 && bars_q == '0 && pending_q == tt_pkg::WK_NONE))
		else $error("reset request left counts behind");

endmodule

// ===== rtl/tempo_tick_generator.sv =====
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle; a full result register that is not taken
// stalls the input. After a configuration write the input holds off while
// the step values are recomputed (multiply stage, step stage).
// Reset: counters zero, no wait pending, transport stopped, default registers.
module tempo_tick_generator #(
	parameter int TICKS_PER_TEMPO_BEAT = tt_pkg::DEF_TICKS_PER_TEMPO_BEAT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // wait_count[15:0]
	input  logic [5:0]                s_tuser,   // req_type[2:0], wait_kind[5:3]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [95:0]               m_tdata,   // tick_count, beat_count, bar_count
	output logic [2:0]                m_tuser,   // ticked[0], event_res[2:1]
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [tt_pkg::CIDX_W-1:0] cfg_index,
	input  logic [tt_pkg::SR_W-1:0]   cfg_data
);

	tt_pkg::rate_cfg_t rate_cfg;
	tt_pkg::result_t   res;
	tt_pkg::result_t   res_s1;
	logic              out_valid_q;
	logic              accept;

	tt_rate #(
		.TICKS_PER_TEMPO_BEAT(TICKS_PER_TEMPO_BEAT)
	) u_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rate_cfg (rate_cfg)
	);

	// Take a request when the step values are settled and the result register is free or being drained.
	assign s_tready = !rate_cfg.busy && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	tt_core #(
		.TICKS_PER_TEMPO_BEAT(TICKS_PER_TEMPO_BEAT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (s_tuser[2:0]),
		.wait_kind (s_tuser[5:3]),
		.wait_count(s_tdata),
		.rate_cfg  (rate_cfg),
		.res       (res)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_s1.bars, res_s1.beats, res_s1.ticks};
	assign m_tuser  = {res_s1.ev, res_s1.ticked};

	// Every accepted request shows a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted request produced no result");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the tempo tick generator: directed transport and wait
// requests, then randomised request streams under several rate settings.
// Depends on tt_pkg and the tempo_tick_generator RTL only.
`timescale 1ns / 100ps

module testbench;

	// Codes above the last defined request type or wait kind.
	localparam logic [2:0] FIRST_UNUSED_CODE = 3'd5;
	localparam logic [2:0] LAST_CODE         = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;  // wait_count[15:0]
	logic [5:0] s_tuser = '0;   // req_type[2:0], wait_kind[5:3]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;       // tick_count[31:0], beat_count[63:32], bar_count[95:64]
	logic [2:0] m_tuser;        // ticked[0], event_res[2:1]
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tt_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [tt_pkg::SR_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;

	// Expected reports, oldest first.
	tt_pkg::result_t due_reports[$];
	tt_pkg::result_t seen, want;

	// Mirror of the rate registers.
	logic [tt_pkg::SR_W-1:0] rate_hz = tt_pkg::DEF_SAMPLE_RATE;
	logic [tt_pkg::TB_W-1:0] tempo_bpp = tt_pkg::DEF_TEMPO_BEATS;
	logic [tt_pkg::PER_W-1:0] period_s = tt_pkg::DEF_PERIOD_SEC;
	logic [tt_pkg::DIV_W-1:0] tpb = tt_pkg::DEF_TICKS_BEAT;
	logic [tt_pkg::DIV_W-1:0] bpb = tt_pkg::DEF_BEATS_BAR;

	// Mirror of the transport state.
	logic [tt_pkg::ACC_W-1:0] acc;
	logic [31:0] n_ticks, n_beats, n_bars, wait_target;
	logic [8:0] ticks_to_beat, beats_to_bar;
	tt_pkg::wait_kind_t pending;
	bit halted = 1'b1;

	tempo_tick_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #6 clk = ~clk;

	function automatic logic [tt_pkg::ACC_W-1:0] samples_per_period();
		return tt_pkg::ACC_W'(rate_hz) * tt_pkg::ACC_W'(period_s);
	endfunction

	function automatic logic [tt_pkg::ACC_W-1:0] ticks_per_period();
		return tt_pkg::ACC_W'(tempo_bpp) * tt_pkg::ACC_W'(tt_pkg::DEF_TICKS_PER_TEMPO_BEAT);
	endfunction

	// Clear the position and any wait, and reload the accumulator.
	function automatic void home_transport();
		n_ticks = '0;
		n_beats = '0;
		n_bars = '0;
		ticks_to_beat = '0;
		beats_to_bar = '0;
		pending = tt_pkg::WK_NONE;
		wait_target = '0;
		acc = (ticks_per_period() << 1) - samples_per_period();
	endfunction

	// A count-based wait is met once the count is at or past the target, modulo wrap.
	function automatic bit target_reached(logic [31:0] count);
		logic [31:0] gap;
		gap = count - wait_target;
		return !gap[31];
	endfunction

	// Apply one request to the mirrored state and return the report it produces.
	function automatic tt_pkg::result_t step_transport(logic [2:0] req, logic [2:0] kind,
			logic [15:0] count);
		tt_pkg::result_t r;
		logic [tt_pkg::ACC_W-1:0] dx, dy;
		dx = samples_per_period();
		dy = ticks_per_period();
		r.ticked = 1'b0;
		r.ev = tt_pkg::EV_NONE;
		case (req)
			tt_pkg::REQ_ADVANCE: begin
				if (!acc[tt_pkg::ACC_W-1]) begin
					acc = acc + (dy << 1) - (dx << 1);
					r.ticked = 1'b1;
					n_ticks++;
					if (ticks_to_beat <= 9'd1) begin
						ticks_to_beat = {1'b0, tpb};
						n_beats++;
						if (beats_to_bar <= 9'd1) begin
							beats_to_bar = {1'b0, bpb};
							n_bars++;
						end else begin
							beats_to_bar--;
						end
					end else begin
						ticks_to_beat--;
					end
					// Waits only fire while the transport runs.
					if (!halted) begin
						case (pending)
							tt_pkg::WK_TICKS: if (target_reached(n_ticks)) begin
								pending = tt_pkg::WK_NONE;
								r.ev = tt_pkg::EV_TICK;
							end
							tt_pkg::WK_BEATS: if (target_reached(n_beats)) begin
								pending = tt_pkg::WK_NONE;
								r.ev = tt_pkg::EV_BEAT;
							end
							tt_pkg::WK_BARS: if (target_reached(n_bars)) begin
								pending = tt_pkg::WK_NONE;
								r.ev = tt_pkg::EV_BAR;
							end
							tt_pkg::WK_NEXT: begin
								pending = tt_pkg::WK_NONE;
								r.ev = tt_pkg::EV_TICK;
							end
							default: ;
						endcase
					end
				end else begin
					acc = acc + (dy << 1);
				end
			end
			tt_pkg::REQ_RESET: home_transport();
			tt_pkg::REQ_ARM: begin
				case (kind)
					tt_pkg::WK_NONE: pending = tt_pkg::WK_NONE;
					tt_pkg::WK_TICKS: begin
						pending = tt_pkg::WK_TICKS;
						wait_target = n_ticks + 32'(count);
					end
					tt_pkg::WK_BEATS: begin
						pending = tt_pkg::WK_BEATS;
						wait_target = n_beats + 32'(count);
					end
					tt_pkg::WK_BARS: begin
						pending = tt_pkg::WK_BARS;
						wait_target = n_bars + 32'(count);
					end
					tt_pkg::WK_NEXT: pending = tt_pkg::WK_NEXT;
					default: ;
				endcase
			end
			tt_pkg::REQ_START: halted = 1'b0;
			tt_pkg::REQ_STOP: begin
				halted = 1'b1;
				pending = tt_pkg::WK_NONE;
			end
			default: ;
		endcase
		r.ticks = n_ticks;
		r.beats = n_beats;
		r.bars = n_bars;
		return r;
	endfunction

	function automatic void report_fault(string what, tt_pkg::result_t exp_r,
			tt_pkg::result_t got_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected ticked=%0b event=%0d ticks=%0d beats=%0d bars=%0d",
				$realtime, what, exp_r.ticked, exp_r.ev, exp_r.ticks, exp_r.beats,
				exp_r.bars);
		if (mismatches <= 10)
			$display("    got ticked=%0b event=%0d ticks=%0d beats=%0d bars=%0d",
				got_r.ticked, got_r.ev, got_r.ticks, got_r.beats, got_r.bars);
	endfunction

	// Take reports with random stalls and compare them against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			seen.ticked = m_tuser[0];
			seen.ev = tt_pkg::event_t'(m_tuser[2:1]);
			seen.ticks = m_tdata[31:0];
			seen.beats = m_tdata[63:32];
			seen.bars = m_tdata[95:64];
			if (due_reports.size() == 0) begin
				report_fault("report with nothing expected", seen, seen);
			end else begin
				want = due_reports.pop_front();
				if (seen.ticked !== want.ticked || seen.ev !== want.ev ||
						seen.ticks !== want.ticks || seen.beats !== want.beats ||
						seen.bars !== want.bars)
					report_fault("report mismatch", want, seen);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one request, with random idle cycles ahead of it, and predict its report.
	task automatic send_request(input logic [2:0] req, input logic [2:0] kind,
			input logic [15:0] count);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {kind, req};
		s_tdata <= count;
		do @(posedge clk); while (!s_tready);
		due_reports.push_back(step_transport(req, kind, count));
	endtask

	// Stop offering requests and wait until every expected report has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input tt_pkg::cfg_idx_t idx,
			input logic [tt_pkg::SR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tt_pkg::CFG_SAMPLE_RATE: rate_hz = value;
			tt_pkg::CFG_TEMPO_BEATS: tempo_bpp = value[tt_pkg::TB_W-1:0];
			tt_pkg::CFG_PERIOD_SEC: period_s = value[tt_pkg::PER_W-1:0];
			tt_pkg::CFG_TICKS_BEAT: tpb = value[tt_pkg::DIV_W-1:0];
			tt_pkg::CFG_BEATS_BAR: bpb = value[tt_pkg::DIV_W-1:0];
			default: ;
		endcase
	endtask

	// Rewrite every rate register once the block has gone quiet.
	task automatic retune(input logic [tt_pkg::SR_W-1:0] sr,
			input logic [tt_pkg::TB_W-1:0] tb, input logic [tt_pkg::PER_W-1:0] per,
			input logic [tt_pkg::DIV_W-1:0] tpb_v, input logic [tt_pkg::DIV_W-1:0] bpb_v);
		drain_results();
		write_register(tt_pkg::CFG_SAMPLE_RATE, sr);
		write_register(tt_pkg::CFG_TEMPO_BEATS, tt_pkg::SR_W'(tb));
		write_register(tt_pkg::CFG_PERIOD_SEC, tt_pkg::SR_W'(per));
		write_register(tt_pkg::CFG_TICKS_BEAT, tt_pkg::SR_W'(tpb_v));
		write_register(tt_pkg::CFG_BEATS_BAR, tt_pkg::SR_W'(bpb_v));
		cfg_valid <= 1'b0;
	endtask

	// One setting: home and start the transport, then a random request mix that is
	// mostly sample advances with waits armed on small counts.
	task automatic run_block(input int n, input logic [tt_pkg::SR_W-1:0] sr,
			input logic [tt_pkg::TB_W-1:0] tb, input logic [tt_pkg::PER_W-1:0] per,
			input logic [tt_pkg::DIV_W-1:0] tpb_v, input logic [tt_pkg::DIV_W-1:0] bpb_v);
		int pick;
		logic [2:0] req, kind;
		logic [15:0] count;
		retune(sr, tb, per, tpb_v, bpb_v);
		send_request(tt_pkg::REQ_RESET, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_START, tt_pkg::WK_NONE, '0);
		repeat (n) begin
			pick = $urandom_range(99);
			req = tt_pkg::REQ_ADVANCE;
			kind = 3'($urandom);
			count = 16'($urandom);
			if (pick < 62) begin
				req = tt_pkg::REQ_ADVANCE;
			end else if (pick < 74) begin
				req = tt_pkg::REQ_ARM;
				kind = 3'($urandom_range(tt_pkg::WK_TICKS, tt_pkg::WK_NEXT));
				if ($urandom_range(15) != 0)
					count = 16'($urandom_range(6));
			end else if (pick < 78) begin
				req = tt_pkg::REQ_ARM;
				kind = 3'($urandom_range(LAST_CODE, FIRST_UNUSED_CODE));
				if ($urandom_range(3) == 0)
					kind = tt_pkg::WK_NONE;
			end else if (pick < 85) begin
				req = tt_pkg::REQ_START;
			end else if (pick < 89) begin
				req = tt_pkg::REQ_STOP;
			end else if (pick < 92) begin
				req = tt_pkg::REQ_RESET;
			end else if (pick < 95) begin
				req = 3'($urandom_range(LAST_CODE, FIRST_UNUSED_CODE));
			end
			send_request(req, kind, count);
		end
	endtask

	// Every request type at the reset rate, while stopped and running.
	task automatic test_transport_requests();
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_START, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, 16'hFFFF);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_TICKS, 16'hFFFF);
		send_request(tt_pkg::REQ_ARM, LAST_CODE, 16'h5A5A);
		send_request(FIRST_UNUSED_CODE, tt_pkg::WK_NEXT, 16'hA5A5);
		send_request(LAST_CODE, LAST_CODE, 16'hFFFF);
		send_request(tt_pkg::REQ_STOP, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_RESET, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
	endtask

	// Each wait kind firing, clearing an armed wait, and stop dropping a pending wait.
	// One sample per second against 24 ticks gives a tick on every sample.
	task automatic test_wait_kinds();
		retune(tt_pkg::SR_W'(1), tt_pkg::TB_W'(1), tt_pkg::PER_W'(1), tt_pkg::DIV_W'(2),
			tt_pkg::DIV_W'(2));
		send_request(tt_pkg::REQ_RESET, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_START, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_NEXT, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_TICKS, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_BEATS, 16'd1);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_BARS, 16'd1);
		repeat (4) send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_TICKS, 16'd1);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ARM, tt_pkg::WK_TICKS, 16'd1);
		send_request(tt_pkg::REQ_STOP, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_START, tt_pkg::WK_NONE, '0);
		send_request(tt_pkg::REQ_ADVANCE, tt_pkg::WK_NONE, '0);
	endtask

	// Sender idles lightly, receiver stalls about half the time; includes the
	// slowest rate, where no tick ever comes.
	task automatic test_sender_idle();
		send_idle_pct = 16;
		recv_idle_pct = 49;
		run_block(220, tt_pkg::SR_W'(100), tt_pkg::TB_W'(3), tt_pkg::PER_W'(1),
			tt_pkg::DIV_W'(4), tt_pkg::DIV_W'(2));
		run_block(220, tt_pkg::SR_W'($urandom_range(300, 10)),
			tt_pkg::TB_W'($urandom_range(10, 1)), tt_pkg::PER_W'($urandom_range(2, 1)),
			tt_pkg::DIV_W'($urandom_range(8)), tt_pkg::DIV_W'($urandom_range(5)));
		run_block(40, tt_pkg::SR_W'(1048575), tt_pkg::TB_W'(1), tt_pkg::PER_W'(65535),
			tt_pkg::DIV_W'(255), tt_pkg::DIV_W'(255));
		run_block(160, tt_pkg::SR_W'($urandom_range(300, 10)),
			tt_pkg::TB_W'($urandom_range(10, 1)), tt_pkg::PER_W'($urandom_range(2, 1)),
			tt_pkg::DIV_W'($urandom_range(8)), tt_pkg::DIV_W'($urandom_range(5)));
	endtask

	// Sender idles about half the time, receiver lightly; includes the largest
	// tempo against the smallest sample count, and the longest divisions.
	task automatic test_receiver_idle();
		send_idle_pct = 49;
		recv_idle_pct = 16;
		run_block(220, tt_pkg::SR_W'(1), tt_pkg::TB_W'(65535), tt_pkg::PER_W'(1),
			tt_pkg::DIV_W'(255), tt_pkg::DIV_W'(255));
		run_block(220, tt_pkg::SR_W'($urandom_range(300, 10)),
			tt_pkg::TB_W'($urandom_range(10, 1)), tt_pkg::PER_W'($urandom_range(2, 1)),
			tt_pkg::DIV_W'($urandom_range(8)), tt_pkg::DIV_W'($urandom_range(5)));
		run_block(200, tt_pkg::SR_W'($urandom_range(300, 10)),
			tt_pkg::TB_W'($urandom_range(10, 1)), tt_pkg::PER_W'($urandom_range(2, 1)),
			tt_pkg::DIV_W'($urandom_range(8)), tt_pkg::DIV_W'($urandom_range(5)));
	endtask

	// Back to back on both sides; includes zero divisions, where every tick is a
	// beat and every beat a bar.
	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_block(220, tt_pkg::SR_W'(30), tt_pkg::TB_W'(1), tt_pkg::PER_W'(1),
			tt_pkg::DIV_W'(0), tt_pkg::DIV_W'(0));
		run_block(220, tt_pkg::SR_W'($urandom_range(300, 10)),
			tt_pkg::TB_W'($urandom_range(10, 1)), tt_pkg::PER_W'($urandom_range(2, 1)),
			tt_pkg::DIV_W'($urandom_range(8)), tt_pkg::DIV_W'($urandom_range(5)));
		run_block(200, tt_pkg::SR_W'($urandom_range(300, 10)),
			tt_pkg::TB_W'($urandom_range(10, 1)), tt_pkg::PER_W'($urandom_range(2, 1)),
			tt_pkg::DIV_W'($urandom_range(8)), tt_pkg::DIV_W'($urandom_range(5)));
	endtask

	initial begin
		home_transport();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_transport_requests();
		test_wait_kinds();
		test_sender_idle();
		test_receiver_idle();
		test_full_rate();
		drain_results();
		// A report is registered in the cycle after its request; allow a few spare.
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_reports.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Give up if the handshakes stop moving.
	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

endmodule
